// ===== hw/rtl/spq_uk_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_uk_pkg
// Shared types, codes and helpers for the sorted priority queue block.
// ----------------------------------------------------------------------------
package spq_uk_pkg;

    // Number of entries the store can hold.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 32;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Request codes carried by the mode field.
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_POP    = 2'd1;
    localparam mode_t MODE_UPDATE = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // One stored word: id in the top byte, then severity, then arrival.
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  sev;
        logic [15:0] arr;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_WR,
        ST_POP_RD,
        ST_POP_HEAD,
        ST_SHF_RD,
        ST_SHF_WR,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_FINISH
    } state_t;

    // True when entry a strictly outranks entry b.
    function automatic logic outranks(entry_t a, entry_t b);
        logic res;
        if (a.sev != b.sev) begin
            res = (a.sev > b.sev);
        end else begin
            res = (a.arr < b.arr);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/stable_priority_queue_update_key.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_update_key
// Sorted priority queue with insert, pop and severity update of an id.
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY entries in a small RAM, sorted by higher
// severity first and earlier arrival among equal severities. One request
// word enters on the s_ channel (valid/ready); exactly one result word
// leaves on the m_ channel (valid/ready) for every request.
//
// A small sequencer walks the RAM one entry at a time; each visited entry
// takes a read state and then a compare or write state, since the RAM read
// is registered. An insert walks from the tail, a pop takes the head and
// shifts the rest up, and an update does all three steps (search, close the
// gap, re-insert); each ends in the finish state that loads the result
// register. A full insert, an empty pop and the unused mode code go straight
// to that state. s_ready is high only while the sequencer is idle, so a new
// request is not taken before the sequencer has finished the last one.
//
// The result sits in an output register, so the next request is taken
// while a result still waits; that request then holds in the finish state
// until the receiver drains the earlier word. Reset (aresetn low, synchronous)
// empties the queue and drops any pending result; RAM contents are not
// cleared, since only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
module stable_priority_queue_update_key (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  spq_uk_pkg::mode_t     s_mode,
    input  logic [7:0]            s_entry_id,
    input  logic [7:0]            s_severity,
    input  logic [15:0]           s_arrival,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [7:0]            m_out_id,
    output logic [7:0]            m_out_severity,
    output logic [15:0]           m_out_arrival
);

    import spq_uk_pkg::*;

    // Sequencer state and bookkeeping.
    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    cnt_t    idx_reg, idx_next;
    mode_t   op_reg, op_next;
    logic [7:0] key_id_reg, key_id_next;
    logic [7:0] key_sev_reg, key_sev_next;

    // Entry being placed, and the result under construction.
    entry_t  ent_reg, ent_next;
    status_t res_status_reg, res_status_next;
    entry_t  res_ent_reg, res_ent_next;

    // Output register.
    logic    m_valid_reg, m_valid_next;
    status_t m_status_reg, m_status_next;
    entry_t  m_ent_reg, m_ent_next;

    // RAM port controls.
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    logic   rd_en;
    idx_t   rd_addr;
    entry_t rd_data;
    logic [ENTRY_W-1:0] rd_word;

    cnt_t idx_inc;
    cnt_t idx_dec;
    cnt_t count_dec;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign rd_data   = entry_t'(rd_word);

    spq_uk_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (CAPACITY)
    ) u_store (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        key_id_reg     <= key_id_next;
        key_sev_reg    <= key_sev_next;
        ent_reg        <= ent_next;
        res_status_reg <= res_status_next;
        res_ent_reg    <= res_ent_next;
        m_status_reg   <= m_status_next;
        m_ent_reg      <= m_ent_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        key_id_next     = key_id_reg;
        key_sev_next    = key_sev_reg;
        ent_next        = ent_reg;
        res_status_next = res_status_reg;
        res_ent_next    = res_ent_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_ent_next      = m_ent_reg;

        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = ent_reg;
        rd_en   = 1'b0;
        rd_addr = idx_reg[IDX_W-1:0];

        s_ready = (state_reg == ST_IDLE);

        // The receiver drains the output register independently of the work.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next         = s_mode;
                    key_id_next     = s_entry_id;
                    key_sev_next    = s_severity;
                    ent_next        = '{id: s_entry_id, sev: s_severity, arr: s_arrival};
                    res_status_next = STAT_OK;
                    res_ent_next    = '0;
                    idx_next        = '0;
                    unique case (s_mode)
                        MODE_INSERT: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                res_status_next = STAT_FULL;
                                state_next      = ST_FINISH;
                            end else if (count_reg == '0) begin
                                state_next = ST_INS_WR;
                            end else begin
                                idx_next   = count_dec;
                                state_next = ST_INS_RD;
                            end
                        end
                        MODE_POP: begin
                            if (count_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                                state_next      = ST_FINISH;
                            end else begin
                                state_next = ST_POP_RD;
                            end
                        end
                        MODE_UPDATE: begin
                            state_next = ST_FIND_RD;
                        end
                        default: begin
                            // The spare mode code is accepted and does nothing.
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            // Insertion walks from the tail toward the head, moving every
            // entry that the new one outranks down by one slot.
            ST_INS_RD: begin
                rd_en      = 1'b1;
                state_next = ST_INS_CMP;
            end

            ST_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = idx_inc[IDX_W-1:0];
                if (outranks(ent_reg, rd_data)) begin
                    wr_data = rd_data;
                    if (idx_reg == '0) begin
                        state_next = ST_INS_WR;
                    end else begin
                        idx_next   = idx_dec;
                        state_next = ST_INS_RD;
                    end
                end else begin
                    wr_data    = ent_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_FINISH;
                end
            end

            ST_INS_WR: begin
                wr_en      = 1'b1;
                wr_data    = ent_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_FINISH;
            end

            ST_POP_RD: begin
                rd_en      = 1'b1;
                state_next = ST_POP_HEAD;
            end

            ST_POP_HEAD: begin
                res_ent_next = rd_data;
                idx_next     = CNT_W'(1);
                state_next   = ST_SHF_RD;
            end

            // Close the gap: move every entry behind the removed one up a slot.
            ST_SHF_RD: begin
                if (idx_reg >= count_reg) begin
                    count_next = count_dec;
                    if (op_reg == MODE_POP) begin
                        state_next = ST_FINISH;
                    end else if (count_dec == '0) begin
                        idx_next   = '0;
                        state_next = ST_INS_WR;
                    end else begin
                        idx_next   = count_dec - CNT_W'(1);
                        state_next = ST_INS_RD;
                    end
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_SHF_WR;
                end
            end

            ST_SHF_WR: begin
                wr_en      = 1'b1;
                wr_addr    = idx_dec[IDX_W-1:0];
                wr_data    = rd_data;
                idx_next   = idx_inc;
                state_next = ST_SHF_RD;
            end

            // Search from the head for the first entry with the requested id.
            ST_FIND_RD: begin
                if (idx_reg >= count_reg) begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = ST_FINISH;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_FIND_CMP;
                end
            end

            ST_FIND_CMP: begin
                idx_next = idx_inc;
                if (rd_data.id == key_id_reg) begin
                    ent_next   = '{id: rd_data.id, sev: key_sev_reg, arr: rd_data.arr};
                    state_next = ST_SHF_RD;
                end else begin
                    state_next = ST_FIND_RD;
                end
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_ent_next    = res_ent_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_id       = m_ent_reg.id;
    assign m_out_severity = m_ent_reg.sev;
    assign m_out_arrival  = m_ent_reg.arr;

endmodule

// ===== hw/rtl/spq_uk_ram.sv =====
// ----------------------------------------------------------------------------
// spq_uk_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spq_uk_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
